// ----- design/osc_adsr_pkg.sv -----
// ----------------------------------------------------------------------------
// osc_adsr_pkg
// shared types, codes and constant tables for the oscillator voice
// ----------------------------------------------------------------------------
`default_nettype none

package osc_adsr_pkg;

   localparam int unsigned SAMPLE_HZ = 44100;

   // register indexes
   localparam logic [2:0] REG_WAVE_SHAPE    = 3'd0;
   localparam logic [2:0] REG_DUTY_CYCLE    = 3'd1;
   localparam logic [2:0] REG_ATTACK_RATE   = 3'd2;
   localparam logic [2:0] REG_DECAY_RATE    = 3'd3;
   localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd4;
   localparam logic [2:0] REG_RELEASE_RATE  = 3'd5;

   // wave shapes
   localparam logic [2:0] WAVE_SQUARE   = 3'd0;
   localparam logic [2:0] WAVE_SINE     = 3'd1;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
   localparam logic [2:0] WAVE_SAW      = 3'd3;
   localparam logic [2:0] WAVE_NOISE    = 3'd4;

   // item modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   typedef enum logic [1:0] {
      ENV_ATTACK  = 2'd0,
      ENV_DECAY   = 2'd1,
      ENV_SUSTAIN = 2'd2,
      ENV_RELEASE = 2'd3
   } env_phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL1,
      ST_MUL2,
      ST_MSER,
      ST_DONE
   } state_type;

   localparam logic [25:0] ENV_TOP  = 26'(255) << 16;
   localparam logic [15:0] LFSR_SEED = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   // q8 frequencies of the top octave
   typedef logic [21:0] top_octave_type [12];
   localparam top_octave_type TOP_OCTAVE_Q8 = '{
      22'd2143237, 22'd2270680, 22'd2405702, 22'd2548752, 22'd2700309, 22'd2860878,
      22'd3030994, 22'd3211227, 22'd3402176, 22'd3604480, 22'd3818814, 22'd4045892
   };

   typedef logic [15:0] rate_rom_type [256];
   typedef logic [15:0] qsine_rom_type [65];

   // q16 envelope step per tick for each rate code
   function automatic rate_rom_type build_rate_rom();
      rate_rom_type rom;
      logic [63:0]  v;
      for (int i = 0; i < 256; i++) begin
         v = (64'(i) * 64'd6553600 + 64'(SAMPLE_HZ / 2)) / SAMPLE_HZ;
         rom[i] = v[15:0];
      end
      return rom;
   endfunction

   // quarter sine at x = k*512, k = 0..64, q15
   function automatic qsine_rom_type build_qsine_rom();
      qsine_rom_type rom;
      logic [63:0]   x;
      logic [63:0]   x2;
      logic [63:0]   t;
      logic [63:0]   r;
      for (int k = 0; k < 65; k++) begin
         x  = 64'(k) * 64'd512;
         x2 = (x * x) >> 15;
         t  = 64'd5026995 - ((x2 * 64'd172272) >> 15);
         t  = 64'd85569306 - ((x2 * t) >> 15);
         t  = 64'd693598668 - ((x2 * t) >> 15);
         t  = 64'd1686629713 - ((x2 * t) >> 15);
         r  = (x * t + (64'd1 << 29)) >> 30;
         rom[k] = r[15:0];
      end
      return rom;
   endfunction

   localparam rate_rom_type  RATE_ROM  = build_rate_rom();
   localparam qsine_rom_type QSINE_ROM = build_qsine_rom();

   // octave of a note number, by threshold count
   function automatic logic [3:0] note_octave(input logic [6:0] n);
      logic [3:0] o;
      o = 4'd0;
      for (int i = 1; i <= 10; i++) begin
         if (n >= 7'(12 * i)) o = o + 4'd1;
      end
      return o;
   endfunction

endpackage

`default_nettype wire

// ----- design/oscillator_voice_with_adsr.sv -----
// ----------------------------------------------------------------------------
// oscillator_voice_with_adsr
// phase accumulator oscillator with five wave shapes and an adsr envelope
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req      | in        | req_valid/req_stall  | mode, note_number, note_level,
//           |           |                      | duration_samples
//  rsp      | out       | rsp_valid/rsp_stall  | sample
//  csr      | in        | apb psel/penable     | paddr, pwdata, prdata
//
//  a start-note transfer has an issue step and then the restoring divider
//  that forms the 24-bit phase step (one quotient bit a cycle)
//  a tick transfer forms wave and envelope at issue, then runs two narrow
//  multiply states, the bit-serial envelope multiply over the 26 envelope
//  bits and a rounding state that loads the output register when it is free
//  a result waits in the output register; a new transfer is taken meanwhile,
//  but the next result only loads once the waiting one has gone
//  reset is synchronous and restores the configuration, the control state and the lfsr seed
// ----------------------------------------------------------------------------
`default_nettype none

module oscillator_voice_with_adsr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_mode,
   input  wire logic [6:0]         req_note_number,
   input  wire logic [7:0]         req_note_level,
   input  wire logic [23:0]        req_duration_samples,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_sample,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [4:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   // configuration
   logic [2:0] wave_shape_ff;
   logic [7:0] duty_cycle_ff, attack_rate_ff, decay_rate_ff;
   logic [7:0] sustain_level_ff, release_rate_ff;

   // voice state
   osc_adsr_pkg::state_type     state_ff, state_in;
   osc_adsr_pkg::env_phase_type env_phase_ff, env_phase_in;
   logic [23:0] phase_acc_ff, phase_acc_in;
   logic [23:0] phase_step_ff, phase_step_in;
   logic [25:0] env_level_ff, env_level_in;
   logic [23:0] samples_left_ff, samples_left_in;
   logic [7:0]  held_level_ff, held_level_in;
   logic [15:0] lfsr_ff, lfsr_in;

   // datapath
   logic [15:0] wmag_ff, wmag_in;
   logic        wneg_ff, wneg_in;
   logic [23:0] prod1_ff, prod1_in;
   logic [57:0] mcand_ff, mcand_in;     // also divisor shifter
   logic [57:0] acc_ff, acc_in;         // also divider remainder
   logic [25:0] env_sh_ff, env_sh_in;
   logic [23:0] quot_ff, quot_in;
   logic [4:0]  cnt_ff, cnt_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_sample_ff, rsp_sample_in;

   logic req_take;
   logic cfg_write;

   assign req_stall  = (state_ff != osc_adsr_pkg::ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;

   // register reads
   always_comb begin
      unique case (csr_paddr[4:2])
         osc_adsr_pkg::REG_WAVE_SHAPE:    csr_prdata = {29'd0, wave_shape_ff};
         osc_adsr_pkg::REG_DUTY_CYCLE:    csr_prdata = {24'd0, duty_cycle_ff};
         osc_adsr_pkg::REG_ATTACK_RATE:   csr_prdata = {24'd0, attack_rate_ff};
         osc_adsr_pkg::REG_DECAY_RATE:    csr_prdata = {24'd0, decay_rate_ff};
         osc_adsr_pkg::REG_SUSTAIN_LEVEL: csr_prdata = {24'd0, sustain_level_ff};
         osc_adsr_pkg::REG_RELEASE_RATE:  csr_prdata = {24'd0, release_rate_ff};
         default:                         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_shape_ff    <= osc_adsr_pkg::WAVE_SQUARE;
         duty_cycle_ff    <= 8'd128;
         attack_rate_ff   <= 8'd255;
         decay_rate_ff    <= 8'd64;
         sustain_level_ff <= 8'd192;
         release_rate_ff  <= 8'd64;
      end else if (cfg_write) begin
         case (csr_paddr[4:2])
            osc_adsr_pkg::REG_WAVE_SHAPE:    wave_shape_ff    <= csr_pwdata[2:0];
            osc_adsr_pkg::REG_DUTY_CYCLE:    duty_cycle_ff    <= csr_pwdata[7:0];
            osc_adsr_pkg::REG_ATTACK_RATE:   attack_rate_ff   <= csr_pwdata[7:0];
            osc_adsr_pkg::REG_DECAY_RATE:    decay_rate_ff    <= csr_pwdata[7:0];
            osc_adsr_pkg::REG_SUSTAIN_LEVEL: sustain_level_ff <= csr_pwdata[7:0];
            osc_adsr_pkg::REG_RELEASE_RATE:  release_rate_ff  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= osc_adsr_pkg::ST_IDLE;
         env_phase_ff    <= osc_adsr_pkg::ENV_ATTACK;
         phase_acc_ff    <= 24'd0;
         phase_step_ff   <= 24'd0;
         env_level_ff    <= 26'd0;
         samples_left_ff <= 24'd0;
         held_level_ff   <= 8'd0;
         lfsr_ff         <= osc_adsr_pkg::LFSR_SEED;
         rsp_valid_ff    <= 1'b0;
         cnt_ff          <= 5'd0;
      end else begin
         state_ff        <= state_in;
         env_phase_ff    <= env_phase_in;
         phase_acc_ff    <= phase_acc_in;
         phase_step_ff   <= phase_step_in;
         env_level_ff    <= env_level_in;
         samples_left_ff <= samples_left_in;
         held_level_ff   <= held_level_in;
         lfsr_ff         <= lfsr_in;
         rsp_valid_ff    <= rsp_valid_in;
         cnt_ff          <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      wmag_ff       <= wmag_in;
      wneg_ff       <= wneg_in;
      prod1_ff      <= prod1_in;
      mcand_ff      <= mcand_in;
      acc_ff        <= acc_in;
      env_sh_ff     <= env_sh_in;
      quot_ff       <= quot_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // next state and datapath
   always_comb begin
      logic [3:0]  oct;
      logic [3:0]  semi;
      logic [57:0] den;
      logic [23:0] phase_sum;
      logic [15:0] ph16;
      logic [16:0] tri2;
      logic [7:0]  sidx;
      logic [6:0]  sk;
      logic [15:0] lfsr_next;
      logic [23:0] sl_dec;
      osc_adsr_pkg::env_phase_type ph_eff;
      logic [15:0] step;
      logic [25:0] env_tmp;
      logic        ge;
      logic [57:0] rnd;
      logic [18:0] omag;
      logic        out_free;

      state_in        = state_ff;
      env_phase_in    = env_phase_ff;
      phase_acc_in    = phase_acc_ff;
      phase_step_in   = phase_step_ff;
      env_level_in    = env_level_ff;
      samples_left_in = samples_left_ff;
      held_level_in   = held_level_ff;
      lfsr_in         = lfsr_ff;
      wmag_in         = wmag_ff;
      wneg_in         = wneg_ff;
      prod1_in        = prod1_ff;
      mcand_in        = mcand_ff;
      acc_in          = acc_ff;
      env_sh_in       = env_sh_ff;
      quot_in         = quot_ff;
      cnt_in          = cnt_ff;
      rsp_sample_in   = rsp_sample_ff;
      out_free        = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      oct       = osc_adsr_pkg::note_octave(req_note_number);
      semi      = 4'(req_note_number - (7'(oct) * 7'd12));
      den       = 58'(osc_adsr_pkg::SAMPLE_HZ) << (5'd18 - 5'(oct));
      phase_sum = phase_acc_ff + phase_step_ff;
      ph16      = phase_sum[23:8];
      tri2      = {ph16, 1'b0};
      sidx      = ph16[15:8];
      sk        = sidx[6] ? (7'd64 - {1'b0, sidx[5:0]}) : {1'b0, sidx[5:0]};
      lfsr_next = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ osc_adsr_pkg::LFSR_TAPS) : (lfsr_ff >> 1);
      sl_dec    = (samples_left_ff != 24'd0) ? samples_left_ff - 24'd1 : samples_left_ff;
      ph_eff    = (sl_dec == 24'd0) ? osc_adsr_pkg::ENV_RELEASE : env_phase_ff;
      step      = 16'd0;
      env_tmp   = env_level_ff;
      ge        = (acc_ff >= mcand_ff);
      rnd       = acc_ff + (58'd1 << 38);
      omag      = rnd[57:39];

      unique case (state_ff)
         osc_adsr_pkg::ST_IDLE: begin
            if (req_take && req_mode == osc_adsr_pkg::MODE_START) begin
               held_level_in   = req_note_level;
               samples_left_in = req_duration_samples;
               env_phase_in    = osc_adsr_pkg::ENV_ATTACK;
               // remainder starts as the rounded dividend
               acc_in   = (58'(osc_adsr_pkg::TOP_OCTAVE_Q8[semi]) << 24) + (den >> 1);
               mcand_in = den << 23;
               quot_in  = 24'd0;
               cnt_in   = 5'd23;
               state_in = osc_adsr_pkg::ST_DIV;
            end else if (req_take) begin
               phase_acc_in = phase_sum;
               wmag_in = 16'd0;
               wneg_in = 1'b0;
               case (wave_shape_ff)
                  osc_adsr_pkg::WAVE_SQUARE: begin
                     wmag_in = 16'h8000;
                     wneg_in = !(ph16 < {duty_cycle_ff, 8'd0});
                  end
                  osc_adsr_pkg::WAVE_SINE: begin
                     wmag_in = osc_adsr_pkg::QSINE_ROM[sk];
                     wneg_in = sidx[7];
                  end
                  osc_adsr_pkg::WAVE_TRIANGLE: begin
                     if (!ph16[15]) begin
                        wneg_in = (tri2 < 17'd32768);
                        wmag_in = wneg_in ? 16'(17'd32768 - tri2) : 16'(tri2 - 17'd32768);
                     end else begin
                        wneg_in = ({1'b0, tri2} > 18'd98304);
                        wmag_in = wneg_in ? 16'({1'b0, tri2} - 18'd98304)
                                          : 16'(18'd98304 - {1'b0, tri2});
                     end
                  end
                  osc_adsr_pkg::WAVE_SAW: begin
                     wneg_in = !ph16[15];
                     wmag_in = wneg_in ? 16'(17'd32768 - {1'b0, ph16}) : {1'b0, ph16[14:0]};
                  end
                  osc_adsr_pkg::WAVE_NOISE: begin
                     lfsr_in = lfsr_next;
                     wneg_in = !lfsr_next[15];
                     wmag_in = wneg_in ? 16'(17'd32768 - {1'b0, lfsr_next})
                                       : {1'b0, lfsr_next[14:0]};
                  end
                  default: ;
               endcase

               // envelope step
               samples_left_in = sl_dec;
               env_phase_in    = ph_eff;
               unique case (ph_eff)
                  osc_adsr_pkg::ENV_ATTACK: begin
                     step    = osc_adsr_pkg::RATE_ROM[attack_rate_ff];
                     env_tmp = env_level_ff + {10'd0, step};
                     if (env_tmp >= osc_adsr_pkg::ENV_TOP)
                        env_phase_in = osc_adsr_pkg::ENV_DECAY;
                  end
                  osc_adsr_pkg::ENV_DECAY: begin
                     step    = osc_adsr_pkg::RATE_ROM[decay_rate_ff];
                     env_tmp = (env_level_ff > {10'd0, step}) ?
                               env_level_ff - {10'd0, step} : 26'd0;
                     if (env_tmp <= {2'd0, sustain_level_ff, 16'd0})
                        env_phase_in = osc_adsr_pkg::ENV_SUSTAIN;
                  end
                  osc_adsr_pkg::ENV_SUSTAIN: ;
                  osc_adsr_pkg::ENV_RELEASE: begin
                     step    = osc_adsr_pkg::RATE_ROM[release_rate_ff];
                     env_tmp = (env_level_ff > {10'd0, step}) ?
                               env_level_ff - {10'd0, step} : 26'd0;
                  end
                  default: ;
               endcase
               env_level_in = env_tmp;
               state_in     = osc_adsr_pkg::ST_MUL1;
            end
         end
         // one quotient bit a cycle
         osc_adsr_pkg::ST_DIV: begin
            if (ge) acc_in = acc_ff - mcand_ff;
            mcand_in = mcand_ff >> 1;
            quot_in  = {quot_ff[22:0], ge};
            cnt_in   = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               phase_step_in = {quot_ff[22:0], ge};
               state_in      = osc_adsr_pkg::ST_IDLE;
            end
         end
         osc_adsr_pkg::ST_MUL1: begin
            prod1_in = wmag_ff * held_level_ff;
            state_in = osc_adsr_pkg::ST_MUL2;
         end
         osc_adsr_pkg::ST_MUL2: begin
            mcand_in  = 58'(32'(prod1_ff) * 32'd90);
            env_sh_in = env_level_ff;
            acc_in    = 58'd0;
            cnt_in    = 5'd25;
            state_in  = osc_adsr_pkg::ST_MSER;
         end
         // shift-add over the envelope bits
         osc_adsr_pkg::ST_MSER: begin
            if (env_sh_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = mcand_ff << 1;
            env_sh_in = env_sh_ff >> 1;
            cnt_in    = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) state_in = osc_adsr_pkg::ST_DONE;
         end
         // round, sign and saturate into the output register
         osc_adsr_pkg::ST_DONE: begin
            if (out_free) begin
               if (wneg_ff)
                  rsp_sample_in = (omag > 19'd32768) ? 16'h8000 : 16'(19'd0 - omag);
               else
                  rsp_sample_in = (omag > 19'd32767) ? 16'h7FFF : omag[15:0];
               rsp_valid_in = 1'b1;
               state_in     = osc_adsr_pkg::ST_IDLE;
            end
         end
         default: state_in = osc_adsr_pkg::ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   // a result only appears after the rounding state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == osc_adsr_pkg::ST_DONE))
      else $error("result without completed multiply");

   // the phase step only changes at the end of a divide
   assert property (@(posedge clock) disable iff (reset)
      !$stable(phase_step_ff) |-> $past(state_ff == osc_adsr_pkg::ST_DIV))
      else $error("phase step changed outside divide");

   // a start note goes to the divider, a tick to the multiplier
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == osc_adsr_pkg::ST_DIV) || (state_ff == osc_adsr_pkg::ST_MUL1))
      else $error("transfer did not start work");

   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_sample_ff))
      else $error("stalled result lost");
`endif

endmodule

`default_nettype wire
